// ===== sv/masked_byte_pattern_scan_top_defines.svh =====
// Assertion macros for the masked byte pattern scan
`ifndef MASKED_BYTE_PATTERN_SCAN_TOP_DEFINES_SVH
`define MASKED_BYTE_PATTERN_SCAN_TOP_DEFINES_SVH

// checked only out of reset
`define MBPS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define MBPS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/mbps_pkg.sv =====
// Shared types and constants of the masked byte pattern scan
`timescale 1ns / 1ps
package mbps_pkg;

  localparam int MAX_PATTERN_BYTES_DEF = 16;
  localparam int PAT_STORE = 16;
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 64;
  localparam int OFS_W = 32;

  localparam logic [1:0] REG_PAT_LO = 2'd0;
  localparam logic [1:0] REG_PAT_HI = 2'd1;
  localparam logic [1:0] REG_CARE = 2'd2;
  localparam logic [1:0] REG_LEN = 2'd3;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

  typedef struct packed {
    logic             found;
    logic [OFS_W-1:0] match_offset;
  } result_t;

endpackage

// ===== sv/mbps_cell.sv =====
// One window cell: holds one byte, compares the byte passing into it
`timescale 1ns / 1ps
module mbps_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  mbps_pkg::cell_ctl_t ctl,
  input  logic [7:0]        byte_in,
  input  logic [7:0]        pat_byte,
  input  logic              care,
  output logic [7:0]        byte_q,
  output logic              mismatch
);
  import mbps_pkg::*;

  logic [7:0] byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r <= '0;
    end else if (ctl.clear) begin
      byte_r <= '0;
    end else if (ctl.shift) begin
      byte_r <= byte_in;
    end
  end

  assign mismatch = care && (byte_in != pat_byte);
  assign byte_q   = byte_r;

endmodule

// ===== sv/mbps_out_buf.sv =====
// Two-entry result buffer between the scan logic and the result channel
`timescale 1ns / 1ps
module mbps_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  mbps_pkg::result_t push_data,
  input  logic              out_stall,
  output logic              out_valid,
  output mbps_pkg::result_t out_data,
  output logic              full
);
  import mbps_pkg::*;

  result_t    slot0_r, slot1_r;
  logic [1:0] cnt_r;
  logic       pop;

  assign pop = (cnt_r != 2'd0) && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (pop && push) begin
      if (cnt_r == 2'd1) begin
        slot0_r <= push_data;
      end else begin
        slot0_r <= slot1_r;
        slot1_r <= push_data;
      end
    end else if (push) begin
      if (cnt_r == 2'd0) begin
        slot0_r <= push_data;
      end else begin
        slot1_r <= push_data;
      end
    end else if (pop) begin
      slot0_r <= slot1_r;
    end
  end

  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = slot0_r;
  assign full      = (cnt_r == 2'd2);

endmodule

// ===== sv/masked_byte_pattern_scan_top.sv =====
// Masked byte pattern scan: top level with register port and cell chain
//
// Bytes of a region enter on the in_ channel, one transfer per byte, with
// in_last_byte marking the region's final byte. A row of cells holds the
// most recent bytes and all positions are compared against the aligned
// pattern in the same cycle. One result per region leaves on the out_
// channel: found=1 with the match start offset as soon as the first match
// ends, else found=0 with offset 0 at the last byte.
// A result is registered in the result buffer when its byte is taken and is
// valid on out_ once earlier results have left. The input takes one byte per
// cycle while the buffer is not full, set by the cell row's single compare stage.
// A two-entry result buffer takes results while the receiver stalls; the
// input stalls only when both entries are held.
// Reset (synchronous, rst_n low) clears the registers, the window, the byte
// count and the buffer. Registers are written over cfg_ (8-byte stride).
`timescale 1ns / 1ps
module masked_byte_pattern_scan_top #(
  parameter int MAX_PATTERN_BYTES = mbps_pkg::MAX_PATTERN_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_data_byte,
  input  logic                        in_last_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_found,
  output logic [mbps_pkg::OFS_W-1:0]  out_match_offset,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [mbps_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [mbps_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [mbps_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                        cfg_pready
);
  import mbps_pkg::*;
  `include "masked_byte_pattern_scan_top_defines.svh"

  localparam int LW = $clog2(MAX_PATTERN_BYTES + 1);

  logic [63:0]      pat_lo_r, pat_hi_r;
  logic [15:0]      care_mask_r;
  logic [4:0]       pat_len_r;
  logic             cfg_wr;
  logic [1:0]       cfg_idx;

  logic [OFS_W-1:0] count_r, count_nxt;
  logic             done_r, done_nxt;

  logic             acc, hit, emit, sat, enough, all_match;
  logic [LW-1:0]    len_c;
  logic [OFS_W-1:0] seen, offset;
  logic [127:0]     pat_all;

  logic [7:0]       cell_in   [MAX_PATTERN_BYTES];
  logic [7:0]       cell_q    [MAX_PATTERN_BYTES];
  logic [7:0]       cell_pat  [MAX_PATTERN_BYTES];
  logic [MAX_PATTERN_BYTES-1:0] cell_care, cell_mis;
  cell_ctl_t        ctl;
  result_t          res;
  result_t          out_data;
  logic             buf_full;

  // register port
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:3];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_lo_r    <= '0;
      pat_hi_r    <= '0;
      care_mask_r <= '0;
      pat_len_r   <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_PAT_LO: pat_lo_r    <= cfg_pwdata;
        REG_PAT_HI: pat_hi_r    <= cfg_pwdata;
        REG_CARE:   care_mask_r <= cfg_pwdata[15:0];
        REG_LEN:    pat_len_r   <= cfg_pwdata[4:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_PAT_LO: cfg_prdata = pat_lo_r;
      REG_PAT_HI: cfg_prdata = pat_hi_r;
      REG_CARE:   cfg_prdata = {48'd0, care_mask_r};
      REG_LEN:    cfg_prdata = {59'd0, pat_len_r};
      default:    cfg_prdata = '0;
    endcase
  end

  // pattern aligned to the window, clamped length
  assign len_c   = (int'(pat_len_r) > MAX_PATTERN_BYTES) ? LW'(MAX_PATTERN_BYTES)
                                                         : LW'(pat_len_r);
  assign pat_all = {pat_hi_r, pat_lo_r};

  always_comb begin
    int         idx_i;
    logic [3:0] idx4;
    for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
      idx_i = int'(len_c) - 1 - j;
      idx4  = 4'(idx_i);
      cell_pat[j]  = 8'd0;
      cell_care[j] = 1'b0;
      if (j < int'(len_c) && idx_i < PAT_STORE) begin
        cell_pat[j]  = pat_all[{idx4, 3'b000} +: 8];
        cell_care[j] = care_mask_r[idx4];
      end
    end
  end

  // cell chain
  assign acc       = in_valid && !in_stall;
  assign ctl.shift = acc;
  assign ctl.clear = acc && in_last_byte;

  for (genvar k = 0; k < MAX_PATTERN_BYTES; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign cell_in[k] = in_data_byte;
    end else begin : g_link
      assign cell_in[k] = cell_q[k-1];
    end
    mbps_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .byte_in  (cell_in[k]),
      .pat_byte (cell_pat[k]),
      .care     (cell_care[k]),
      .byte_q   (cell_q[k]),
      .mismatch (cell_mis[k])
    );
  end

  assign all_match = ~|cell_mis;

  // count, match decision
  assign sat    = (count_r == '1);
  assign seen   = sat ? count_r : count_r + OFS_W'(1);
  assign enough = (len_c == '0) || (count_r >= OFS_W'(len_c) - OFS_W'(1));
  assign offset = (len_c == '0) ? '0
                : count_r - OFS_W'(len_c) + (sat ? OFS_W'(0) : OFS_W'(1));
  assign hit    = !done_r && enough && all_match;
  assign emit   = acc && (hit || (in_last_byte && !done_r));

  assign res.found        = hit;
  assign res.match_offset = hit ? offset : '0;

  always_comb begin
    count_nxt = count_r;
    done_nxt  = done_r;
    if (acc) begin
      if (in_last_byte) begin
        count_nxt = '0;
        done_nxt  = 1'b0;
      end else begin
        count_nxt = seen;
        done_nxt  = done_r || hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      done_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      done_r  <= done_nxt;
    end
  end

  mbps_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (emit),
    .push_data (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .full      (buf_full)
  );

  assign in_stall         = buf_full;
  assign out_found        = out_data.found;
  assign out_match_offset = out_data.match_offset;

  `MBPS_ASSERT(a_hit_sets_done, (acc && hit && !in_last_byte) |=> done_r, "match not latched")
  `MBPS_ASSERT(a_last_clears, (acc && in_last_byte) |=> (count_r == '0 && !done_r), "region end not cleared")
  `MBPS_ASSERT(a_notfound_zero, (out_valid && !out_found) |-> (out_match_offset == '0), "not-found offset nonzero")
  `MBPS_ASSERT_ALWAYS(a_stall_has_result, in_stall |-> out_valid, "input stalled with empty buffer")

endmodule
